FILE: rtl/core/midi_byte_stream_parser_defines.svh
// ----------------------------------------------------------------------------
// MIDI parser assertion macros
// Shared concurrent assertion forms used by the parser modules.
// ----------------------------------------------------------------------------
`ifndef MIDI_BYTE_STREAM_PARSER_DEFINES_SVH
`define MIDI_BYTE_STREAM_PARSER_DEFINES_SVH

// A property that must hold at every clock edge outside of reset.
`define MBP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must never be seen outside of reset.
`define MBP_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/core/mbp_pkg.sv
// ----------------------------------------------------------------------------
// MIDI parser package
// Event word layout, event kinds and controller/datapath handshake structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbp_pkg;

	localparam int DEF_SYSEX_DEPTH = 64;

	typedef enum logic [4:0] {
		KIND_NOTE_OFF   = 5'd0,
		KIND_NOTE_ON    = 5'd1,
		KIND_POLY_AT    = 5'd2,
		KIND_CTRL       = 5'd3,
		KIND_PROGRAM    = 5'd4,
		KIND_CHAN_AT    = 5'd5,
		KIND_BEND       = 5'd6,
		KIND_QFRAME     = 5'd7,
		KIND_SONG_POS   = 5'd8,
		KIND_SONG_SEL   = 5'd9,
		KIND_TUNE       = 5'd10,
		KIND_SYSEX_BYTE = 5'd11,
		KIND_CLOCK      = 5'd12,
		KIND_START      = 5'd13,
		KIND_CONTINUE   = 5'd14,
		KIND_STOP       = 5'd15,
		KIND_SENSING    = 5'd16,
		KIND_RESET      = 5'd17
	} mbp_kind_t;

	typedef struct packed {
		mbp_kind_t   event_kind;
		logic [3:0]  channel;
		logic [6:0]  data_first;
		logic [6:0]  data_second;
		logic [13:0] value_wide;
		logic [7:0]  sysex_data;
		logic        last_of_run;
	} mbp_event_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take_byte;
		logic rel_load;
		logic rel_finish;
	} mbp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic rel_req;
		logic rel_last;
		logic out_free;
	} mbp_sts_t;

endpackage

FILE: rtl/core/mbp_byte_if.sv
// ----------------------------------------------------------------------------
// MIDI byte channel
// Valid/ready channel carrying one received MIDI byte per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mbp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/core/mbp_event_if.sv
// ----------------------------------------------------------------------------
// MIDI event channel
// Valid/ready channel carrying one decoded MIDI event per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mbp_event_if;
	logic        valid;
	logic        ready;
	logic [4:0]  event_kind;
	logic [3:0]  channel;
	logic [6:0]  data_first;
	logic [6:0]  data_second;
	logic [13:0] value_wide;
	logic [7:0]  sysex_data;
	logic        last_of_run;

	modport source (
		output valid, output event_kind, output channel, output data_first,
		output data_second, output value_wide, output sysex_data, output last_of_run,
		input ready
	);
	modport sink (
		input valid, input event_kind, input channel, input data_first,
		input data_second, input value_wide, input sysex_data, input last_of_run,
		output ready
	);
endinterface

FILE: rtl/core/mbp_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/mbp_ctrl.sv
// ----------------------------------------------------------------------------
// MIDI parser controller
// Gates byte intake and sequences the SysEx release out of the buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "midi_byte_stream_parser_defines.svh"

module mbp_ctrl import mbp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     rx_valid,
	output logic     rx_ready,
	input  mbp_sts_t sts,
	output mbp_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REL_READ,
		ST_REL_SEND
	} state_t;

	state_t state_q;

	// A byte is taken only when the output register can hold its event.
	assign rx_ready       = (state_q == ST_IDLE) && sts.out_free;
	assign cmd.take_byte  = rx_valid && rx_ready;
	assign cmd.rel_load   = (state_q == ST_REL_SEND) && sts.out_free;
	assign cmd.rel_finish = cmd.rel_load && sts.rel_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.take_byte && sts.rel_req) begin
						state_q <= ST_REL_READ;
					end
				end
				ST_REL_READ: begin
					state_q <= ST_REL_SEND;
				end
				ST_REL_SEND: begin
					if (cmd.rel_finish) begin
						state_q <= ST_IDLE;
					end else if (cmd.rel_load) begin
						state_q <= ST_REL_READ;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`MBP_ASSERT(a_eox_starts_release, clk, arst_n, (cmd.take_byte && sts.rel_req) |=> (state_q == ST_REL_READ), "EOX did not start a release")
	`MBP_ASSERT(a_send_after_read, clk, arst_n, (state_q == ST_REL_SEND) |-> ($past(state_q) == ST_REL_READ || $past(state_q) == ST_REL_SEND), "release send without a buffer read")
	`MBP_ASSERT(a_finish_to_idle, clk, arst_n, cmd.rel_finish |=> (state_q == ST_IDLE), "release did not end in idle")

endmodule

FILE: rtl/core/mbp_datapath.sv
// ----------------------------------------------------------------------------
// MIDI parser datapath
// Parse state, SysEx buffer, event decode and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "midi_byte_stream_parser_defines.svh"

module mbp_datapath import mbp_pkg::*; #(
	parameter int SYSEX_DEPTH = DEF_SYSEX_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] rx_byte,
	input  logic       evt_ready,
	input  mbp_cmd_t   cmd,
	output mbp_sts_t   sts,
	output logic       evt_valid,
	output mbp_event_t evt_word
);

	localparam int FW = $clog2(SYSEX_DEPTH + 1);
	localparam int AW = $clog2(SYSEX_DEPTH);

	localparam logic [7:0] BYTE_CHAN_FIRST = 8'h80;
	localparam logic [7:0] BYTE_CHAN_LAST  = 8'hEF;
	localparam logic [7:0] BYTE_SYSEX      = 8'hF0;
	localparam logic [7:0] BYTE_QFRAME     = 8'hF1;
	localparam logic [7:0] BYTE_SONG_POS   = 8'hF2;
	localparam logic [7:0] BYTE_SONG_SEL   = 8'hF3;
	localparam logic [7:0] BYTE_TUNE       = 8'hF6;
	localparam logic [7:0] BYTE_EOX        = 8'hF7;
	localparam logic [7:0] BYTE_CLOCK      = 8'hF8;
	localparam logic [7:0] BYTE_START      = 8'hFA;
	localparam logic [7:0] BYTE_CONTINUE   = 8'hFB;
	localparam logic [7:0] BYTE_STOP       = 8'hFC;
	localparam logic [7:0] BYTE_SENSING    = 8'hFE;
	localparam logic [7:0] BYTE_RESET      = 8'hFF;

	localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
	localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
	localparam logic [3:0] NIB_POLY_AT  = 4'hA;
	localparam logic [3:0] NIB_CTRL     = 4'hB;
	localparam logic [3:0] NIB_PROGRAM  = 4'hC;
	localparam logic [3:0] NIB_CHAN_AT  = 4'hD;
	localparam logic [3:0] NIB_BEND     = 4'hE;

	typedef enum logic [1:0] {
		MODE_STATUS,
		MODE_DATA,
		MODE_SYSEX
	} mode_t;

	mode_t           mode_q, mode_n;
	logic [7:0]      head_q, head_n;
	logic [6:0]      d1_q, d1_n;
	logic [FW-1:0]   fill_q, fill_n, fill_inc;
	logic [7:0]      rs_q, rs_n;
	logic [AW-1:0]   idx_q;
	logic            out_valid_q;
	mbp_event_t      out_q;

	logic            abort;
	logic            ev_hit;
	logic            rel_req;
	mbp_event_t      ev;
	mbp_event_t      rel_ev;
	logic            ram_we;
	logic [7:0]      ram_rdata;
	logic            head_two;
	logic            rs_two;

	function automatic mbp_event_t chan_event(input logic [7:0] status,
	                                          input logic [6:0] d1,
	                                          input logic [6:0] d2);
		mbp_event_t e;
		e             = '0;
		e.channel     = status[3:0];
		e.last_of_run = 1'b1;
		case (status[7:4])
			NIB_NOTE_OFF: begin
				e.event_kind  = KIND_NOTE_OFF;
				e.data_first  = d1;
				e.data_second = d2;
			end
			NIB_NOTE_ON: begin
				// A note-on with zero velocity is a note-off.
				e.event_kind  = (d2 == 7'd0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
				e.data_first  = d1;
				e.data_second = d2;
			end
			NIB_POLY_AT: begin
				e.event_kind  = KIND_POLY_AT;
				e.data_first  = d1;
				e.data_second = d2;
			end
			NIB_CTRL: begin
				e.event_kind  = KIND_CTRL;
				e.data_first  = d1;
				e.data_second = d2;
			end
			NIB_PROGRAM: begin
				e.event_kind = KIND_PROGRAM;
				e.data_first = d1;
			end
			NIB_CHAN_AT: begin
				e.event_kind = KIND_CHAN_AT;
				e.data_first = d1;
			end
			NIB_BEND: begin
				e.event_kind = KIND_BEND;
				e.value_wide = {d2, d1};
			end
			default: begin
				e.event_kind = KIND_NOTE_OFF;
			end
		endcase
		return e;
	endfunction

	assign head_two = (head_q[7:4] == NIB_PROGRAM) || (head_q[7:4] == NIB_CHAN_AT);
	assign rs_two   = (rs_q[7:4] == NIB_PROGRAM) || (rs_q[7:4] == NIB_CHAN_AT);
	assign fill_inc = fill_q + FW'(1);

	always_comb begin
		mode_n  = mode_q;
		head_n  = head_q;
		d1_n    = d1_q;
		fill_n  = fill_q;
		rs_n    = rs_q;
		abort   = 1'b0;
		ev_hit  = 1'b0;
		ram_we  = 1'b0;
		rel_req = 1'b0;
		ev             = '0;
		ev.last_of_run = 1'b1;

		if (rx_byte[7]) begin
			if (rx_byte <= BYTE_CHAN_LAST) begin
				// A channel status always becomes running status, even when it aborts.
				rs_n = rx_byte;
				if (mode_q == MODE_STATUS) begin
					head_n = rx_byte;
					fill_n = fill_inc;
					mode_n = MODE_DATA;
				end else begin
					abort = 1'b1;
				end
			end else if (rx_byte <= BYTE_EOX) begin
				rs_n = '0;
				case (mode_q)
					MODE_STATUS: begin
						if (rx_byte == BYTE_SYSEX) begin
							head_n = rx_byte;
							ram_we = 1'b1;
							fill_n = fill_inc;
							mode_n = MODE_SYSEX;
						end else if (rx_byte == BYTE_QFRAME || rx_byte == BYTE_SONG_POS ||
						             rx_byte == BYTE_SONG_SEL) begin
							head_n = rx_byte;
							fill_n = fill_inc;
							mode_n = MODE_DATA;
						end else if (rx_byte == BYTE_TUNE) begin
							ev_hit        = 1'b1;
							ev.event_kind = KIND_TUNE;
						end
					end
					MODE_SYSEX: begin
						// The buffer is kept until the release sequence has read it out.
						if (rx_byte == BYTE_EOX) begin
							rel_req = 1'b1;
						end else begin
							abort = 1'b1;
						end
					end
					default: begin
						abort = 1'b1;
					end
				endcase
			end else begin
				ev_hit = 1'b1;
				case (rx_byte)
					BYTE_CLOCK:    ev.event_kind = KIND_CLOCK;
					BYTE_START:    ev.event_kind = KIND_START;
					BYTE_CONTINUE: ev.event_kind = KIND_CONTINUE;
					BYTE_STOP:     ev.event_kind = KIND_STOP;
					BYTE_SENSING:  ev.event_kind = KIND_SENSING;
					BYTE_RESET:    ev.event_kind = KIND_RESET;
					default: begin
						ev_hit = 1'b0;
						abort  = 1'b1;
					end
				endcase
			end
		end else begin
			if (head_q >= BYTE_CHAN_FIRST && head_q <= BYTE_CHAN_LAST) begin
				if (head_two || fill_q == FW'(2)) begin
					ev_hit = 1'b1;
					ev     = chan_event(head_q, head_two ? rx_byte[6:0] : d1_q,
					                    head_two ? 7'd0 : rx_byte[6:0]);
					abort  = 1'b1;
				end else begin
					d1_n   = rx_byte[6:0];
					fill_n = fill_inc;
				end
			end else if (head_q >= BYTE_SYSEX && head_q <= BYTE_EOX) begin
				if (mode_q == MODE_SYSEX) begin
					ram_we = 1'b1;
					fill_n = fill_inc;
					// A full buffer drops the SysEx without a trace.
					if (fill_inc >= FW'(SYSEX_DEPTH)) begin
						abort = 1'b1;
					end
				end else if (mode_q == MODE_DATA) begin
					if (head_q == BYTE_QFRAME || head_q == BYTE_SONG_SEL) begin
						ev_hit        = 1'b1;
						ev.event_kind = (head_q == BYTE_QFRAME) ? KIND_QFRAME : KIND_SONG_SEL;
						ev.data_first = rx_byte[6:0];
						abort         = 1'b1;
					end else if (head_q == BYTE_SONG_POS) begin
						if (fill_q == FW'(2)) begin
							ev_hit        = 1'b1;
							ev.event_kind = KIND_SONG_POS;
							ev.value_wide = {rx_byte[6:0], d1_q};
							abort         = 1'b1;
						end else begin
							d1_n   = rx_byte[6:0];
							fill_n = fill_inc;
						end
					end else begin
						abort = 1'b1;
					end
				end else begin
					abort = 1'b1;
				end
			end else if (head_q == 8'h00 && rs_q != 8'h00) begin
				// Running status: the stored status stands in for a fresh one.
				if (rs_two) begin
					ev_hit = 1'b1;
					ev     = chan_event(rs_q, rx_byte[6:0], 7'd0);
				end else begin
					head_n = rs_q;
					d1_n   = rx_byte[6:0];
					fill_n = FW'(2);
					mode_n = MODE_DATA;
				end
			end
		end

		if (abort) begin
			mode_n = MODE_STATUS;
			head_n = '0;
			fill_n = '0;
		end
	end

	assign sts.rel_req  = rel_req;
	assign sts.rel_last = ((FW'(idx_q) + FW'(1)) == fill_q);
	assign sts.out_free = !out_valid_q || evt_ready;

	always_comb begin
		rel_ev             = '0;
		rel_ev.event_kind  = KIND_SYSEX_BYTE;
		rel_ev.sysex_data  = ram_rdata;
		rel_ev.last_of_run = sts.rel_last;
	end

	mbp_ram #(
		.WIDTH (8),
		.DEPTH (SYSEX_DEPTH)
	) u_sysex_ram (
		.clk   (clk),
		.we    (cmd.take_byte && ram_we),
		.waddr (fill_q[AW-1:0]),
		.wdata (rx_byte),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_STATUS;
			head_q      <= '0;
			fill_q      <= '0;
			rs_q        <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.take_byte) begin
				mode_q <= mode_n;
				head_q <= head_n;
				fill_q <= fill_n;
				rs_q   <= rs_n;
			end
			if (cmd.rel_finish) begin
				mode_q <= MODE_STATUS;
				head_q <= '0;
				fill_q <= '0;
				idx_q  <= '0;
			end else if (cmd.rel_load) begin
				idx_q <= idx_q + AW'(1);
			end
			if ((cmd.take_byte && ev_hit) || cmd.rel_load) begin
				out_valid_q <= 1'b1;
			end else if (evt_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_byte) begin
			d1_q <= d1_n;
		end
		if (cmd.rel_load) begin
			out_q <= rel_ev;
		end else if (cmd.take_byte && ev_hit) begin
			out_q <= ev;
		end
	end

	assign evt_valid = out_valid_q;
	assign evt_word  = out_q;

	`MBP_ASSERT(a_fill_bounded, clk, arst_n, fill_q < FW'(SYSEX_DEPTH), "fill position reached the buffer depth")
	`MBP_ASSERT(a_idle_mode_head, clk, arst_n, (mode_q == MODE_STATUS) == (head_q == 8'h00), "parse mode and stored status disagree")
	`MBP_ASSERT(a_sysex_head, clk, arst_n, (mode_q == MODE_SYSEX) |-> (head_q == BYTE_SYSEX), "SysEx mode without a SysEx start")

endmodule

FILE: rtl/core/midi_byte_stream_parser.sv
// ----------------------------------------------------------------------------
// MIDI byte stream parser
// Decodes received MIDI bytes into events, with running status and SysEx.
// ----------------------------------------------------------------------------
//  channel  direction  word contents
//  rx       in         rx_byte: one received MIDI byte
//  evt      out        event_kind, channel, data bytes, 14-bit value,
//                      SysEx byte, last_of_run
//
// A byte is taken and its event, if any, sits in the output register.
// On EOX a SysEx of n buffered bytes is read out of the buffer RAM one byte
// at a time (registered read, then load), each load waiting out any output stall;
// no byte is taken during that run.
// Reset clears the parse state at once; the buffer needs no clearing pass.
// The rx side is held off while the output register holds an event not taken.
`timescale 1ns / 1ps

module midi_byte_stream_parser import mbp_pkg::*; #(
	parameter int SYSEX_DEPTH = DEF_SYSEX_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	mbp_byte_if.sink   rx,
	mbp_event_if.source evt
);

	mbp_cmd_t   cmd;
	mbp_sts_t   sts;
	mbp_event_t evt_word;

	mbp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx.valid),
		.rx_ready (rx.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mbp_datapath #(
		.SYSEX_DEPTH (SYSEX_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_byte   (rx.rx_byte),
		.evt_ready (evt.ready),
		.cmd       (cmd),
		.sts       (sts),
		.evt_valid (evt.valid),
		.evt_word  (evt_word)
	);

	assign evt.event_kind  = evt_word.event_kind;
	assign evt.channel     = evt_word.channel;
	assign evt.data_first  = evt_word.data_first;
	assign evt.data_second = evt_word.data_second;
	assign evt.value_wide  = evt_word.value_wide;
	assign evt.sysex_data  = evt_word.sysex_data;
	assign evt.last_of_run = evt_word.last_of_run;

endmodule
